// ===== rtl/csrle_pkg.sv =====
// Shared types and constants for the chart scanline run-length decoder.
`timescale 1ns / 1ps

package csrle_pkg;

  localparam int unsigned MAX_WIDTH = 16384;
  localparam int unsigned MAX_LINES = 16384;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_COLOR_SIZE = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] REG_LINE_COUNT = 2'd2;
  localparam logic [1:0] REG_OBFUSCATED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [7:0] OBF_OFFSET = 8'd9;

  typedef struct packed {
    logic [6:0]  run_value;
    logic [14:0] run_length;
    logic        line_end;
    logic [1:0]  status;
    logic [13:0] line_number;
  } run_t;

endpackage

// ===== rtl/chart_scanline_rle_decoder_core.sv =====
// Top level: chart scanline run-length decoder with APB register port.
//
// Usage:
//   Compressed raster bytes enter on data_byte with data_valid/data_stall; a
//   byte transfers at a clock edge with data_valid high and data_stall low.
//   Decoded runs leave on run_value/run_length/line_end/status/line_number
//   with run_valid/run_stall, same transfer rule. A byte yields zero or one
//   run: line markers and run or count bytes with more count bytes to follow
//   yield none, the line terminator yields a pad run, a bad marker yields one
//   flagged result and the bytes up to the next terminator are dropped.
//   A run is registered in the output register, or in the skid register when
//   run_stall holds. Throughput: one byte per cycle while data_stall is low;
//   the decode of each byte is a single pass of shifts, masks and a compare
//   against the line state. When run_stall holds, one more result lands in a
//   skid register and data_stall rises with it; it falls once the skid drains.
//   data_stall is a register, so there is no path from run_stall to it.
//   Reset (rst, synchronous) restores the register defaults and starts at
//   line 0 expecting a line marker; no results are pending afterwards.
//   Registers are to be written only while no byte is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module chart_scanline_rle_decoder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csrle_pkg::ADDR_W-1:0]   paddr,
  input  logic [csrle_pkg::DATA_W-1:0]   pwdata,
  output logic [csrle_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           data_valid,
  output logic                           data_stall,
  input  logic [7:0]                     data_byte,
  output logic                           run_valid,
  input  logic                           run_stall,
  output logic [6:0]                     run_value,
  output logic [14:0]                    run_length,
  output logic                           line_end,
  output logic [1:0]                     status,
  output logic [13:0]                    line_number
);
  import csrle_pkg::*;

  typedef enum logic [1:0] {
    PH_MARKER,
    PH_RUN,
    PH_CONT,
    PH_DISCARD
  } phase_t;

  localparam logic [14:0] WIDTH_LIM = 15'(MAX_WIDTH);
  localparam logic [14:0] LINES_LIM = 15'(MAX_LINES);

  // configuration
  logic [2:0]  color_size;
  logic [14:0] line_width;
  logic [14:0] line_count;
  logic        obfuscated_mode;

  // decode state
  phase_t      phase, phase_next;
  logic [15:0] marker_accum, marker_accum_next;
  logic [6:0]  run_value_hold, run_value_hold_next;
  logic [14:0] run_count_accum, run_count_accum_next;
  logic [14:0] pixel_position, pixel_position_next;
  logic [13:0] line_index, line_index_next;

  // output register and skid
  run_t        out_q, skid_q, res;
  logic        skid_valid;
  logic        res_valid;

  logic        wr_en;
  logic        accept;
  logic        out_free;
  logic [7:0]  b;
  logic [2:0]  sh;
  logic [14:0] eff_width, eff_lines, remain;
  logic [22:0] marker_sum;
  logic [21:0] count_sum;
  logic [6:0]  vmask, cmask;
  logic [15:0] len_full;
  logic [14:0] emit_len;
  logic [14:0] line_inc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_COLOR_SIZE: prdata = DATA_W'(color_size);
      REG_LINE_WIDTH: prdata = DATA_W'(line_width);
      REG_LINE_COUNT: prdata = DATA_W'(line_count);
      REG_OBFUSCATED: prdata = DATA_W'(obfuscated_mode);
      default:        prdata = '0;
    endcase
  end

  assign accept     = data_valid && !data_stall;
  assign data_stall = skid_valid;
  assign out_free   = !run_valid || !run_stall;

  always_comb begin
    b         = obfuscated_mode ? (data_byte - OBF_OFFSET) : data_byte;
    sh        = 3'd7 - color_size;
    vmask     = 7'h7f >> sh;
    cmask     = ~(7'(7'h7f << sh));
    eff_width = (line_width > WIDTH_LIM) ? WIDTH_LIM : line_width;
    eff_lines = (line_count > LINES_LIM) ? LINES_LIM : line_count;
    remain    = (pixel_position < eff_width) ? (eff_width - pixel_position) : 15'd0;
    line_inc  = {1'b0, line_index} + 15'd1;

    marker_sum = {marker_accum, 7'b0} + 23'(b[6:0]);
    count_sum  = {run_count_accum, 7'b0} + 22'(b[6:0]);

    phase_next           = phase;
    marker_accum_next    = marker_accum;
    run_value_hold_next  = run_value_hold;
    run_count_accum_next = run_count_accum;
    pixel_position_next  = pixel_position;
    line_index_next      = line_index;
    res_valid            = 1'b0;
    res.run_value        = '0;
    res.run_length       = '0;
    res.line_end         = 1'b0;
    res.status           = ST_OK;
    res.line_number      = line_index;

    unique case (phase)
      PH_MARKER: begin
        // leading zeros of a marker are skipped after line 0
        if (!(line_index != '0 && marker_accum == '0 && b == '0)) begin
          marker_accum_next = (|marker_sum[22:16]) ? 16'hffff : marker_sum[15:0];
          if (!b[7]) begin
            if ({1'b0, line_index} >= eff_lines) begin
              res_valid    = 1'b1;
              res.line_end = 1'b1;
              res.status   = ST_RANGE;
              phase_next   = PH_DISCARD;
            end else if (marker_accum_next != {2'b0, line_index} &&
                         marker_accum_next != {1'b0, line_inc}) begin
              res_valid    = 1'b1;
              res.line_end = 1'b1;
              res.status   = ST_MISMATCH;
              phase_next   = PH_DISCARD;
            end else begin
              phase_next          = PH_RUN;
              pixel_position_next = '0;
            end
          end
        end
      end
      PH_DISCARD: begin
        if (b == '0) begin
          line_index_next     = line_index + 14'd1;
          phase_next          = PH_MARKER;
          marker_accum_next   = '0;
          pixel_position_next = '0;
        end
      end
      PH_RUN: begin
        if (b == '0) begin
          // line terminator: pad the rest of the line
          res_valid           = 1'b1;
          res.run_length      = remain;
          res.line_end        = 1'b1;
          line_index_next     = line_index + 14'd1;
          phase_next          = PH_MARKER;
          marker_accum_next   = '0;
          pixel_position_next = '0;
        end else begin
          run_value_hold_next  = (b[6:0] >> sh) & vmask;
          run_count_accum_next = 15'(b[6:0] & cmask);
          if (b[7]) phase_next = PH_CONT;
        end
      end
      PH_CONT: begin
        run_count_accum_next = (|count_sum[21:15]) ? 15'h7fff : count_sum[14:0];
      end
      default: ;
    endcase

    // run emission shared by a short run byte and the last count byte
    len_full = {1'b0, run_count_accum_next} + 16'd1;
    emit_len = (len_full > {1'b0, remain}) ? remain : len_full[14:0];
    if ((phase == PH_RUN && b != '0 && !b[7]) || (phase == PH_CONT && !b[7])) begin
      res_valid           = 1'b1;
      res.run_value       = run_value_hold_next;
      res.run_length      = emit_len;
      pixel_position_next = pixel_position + emit_len;
      phase_next          = PH_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_size      <= 3'd7;
      line_width      <= WIDTH_LIM;
      line_count      <= LINES_LIM;
      obfuscated_mode <= 1'b0;
      phase           <= PH_MARKER;
      marker_accum    <= '0;
      run_value_hold  <= '0;
      run_count_accum <= '0;
      pixel_position  <= '0;
      line_index      <= '0;
      run_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (paddr[3:2])
          REG_COLOR_SIZE: color_size      <= pwdata[2:0];
          REG_LINE_WIDTH: line_width      <= pwdata[14:0];
          REG_LINE_COUNT: line_count      <= pwdata[14:0];
          REG_OBFUSCATED: obfuscated_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        phase           <= phase_next;
        marker_accum    <= marker_accum_next;
        run_value_hold  <= run_value_hold_next;
        run_count_accum <= run_count_accum_next;
        pixel_position  <= pixel_position_next;
        line_index      <= line_index_next;
      end
      if (skid_valid) begin
        if (out_free) begin
          out_q      <= skid_q;
          run_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_free) begin
          out_q     <= res;
          run_valid <= 1'b1;
        end else begin
          skid_q     <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        run_valid <= 1'b0;
      end
    end
  end

  assign run_value   = out_q.run_value;
  assign run_length  = out_q.run_length;
  assign line_end    = out_q.line_end;
  assign status      = out_q.status;
  assign line_number = out_q.line_number;

  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> run_valid)
    else $error("skid register full while output register empty");

  // flagged results carry no pixels and close the line
  a_flag_shape: assert property (@(posedge clk) disable iff (rst)
    (run_valid && status != ST_OK) |->
      (line_end && run_length == '0 && run_value == '0))
    else $error("flagged result with pixels or without line end");

  // no run is longer than the widest line
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run_length <= WIDTH_LIM))
    else $error("run length beyond line width limit");

  // a held skid register drains once run_stall is low
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !run_stall) |=> !skid_valid)
    else $error("skid register did not drain");

endmodule
